// ===== src/pge_pkg.sv =====
`default_nettype none
package pge_pkg;

   localparam int QfBits = 56;

   localparam logic [63:0] One = 64'h0100_0000_0000_0000;
   localparam logic [63:0] EpsCap = 64'h3000_0000_0000_0000;
   localparam logic [63:0] Thr100 = One / 100;
   localparam logic [63:0] Thr1000 = One / 1000;
   localparam logic [62:0] Sat63 = '1;

   localparam logic [127:0] DecScale = 128'd1000000000000000000;

   localparam logic [63:0] CoefA1 = 64'((128'd51329911273420320 << QfBits) / DecScale);
   localparam logic [63:0] CoefA2 = 64'((128'd19248716727532620 << QfBits) / DecScale);
   localparam logic [63:0] CoefP1 = 64'((128'd1280733976612035400 << QfBits) / DecScale);
   localparam logic [63:0] CoefP2 = 64'((128'd857872251331172400 << QfBits) / DecScale);
   localparam logic [63:0] CoefP3 = 64'((128'd332889086144280980 << QfBits) / DecScale);
   localparam logic [63:0] CoefP4 = 64'((128'd79984931563508915 << QfBits) / DecScale);
   localparam logic [63:0] CoefP5 = 64'((128'd11878558806454416 << QfBits) / DecScale);
   localparam logic [63:0] CoefQ1 = 64'((128'd280733975874400000 << QfBits) / DecScale);
   localparam logic [63:0] CoefQ2 = 64'((128'd77138641075380000 << QfBits) / DecScale);
   localparam logic [63:0] CoefS3 = 64'((128'd38497433455066257 << QfBits) / DecScale);
   localparam logic [63:0] CoefS4 = 64'((128'd19248716727533128 << QfBits) / DecScale);
   localparam logic [63:0] CoefS5 = 64'((128'd3208119454588855 << QfBits) / DecScale);
   localparam logic [63:0] CoefS7 = 64'((128'd53468657576481 << QfBits) / DecScale);
   localparam logic [63:0] CoefNorm = 64'((128'd153989733820265028 << QfBits) / DecScale);

   localparam logic [31:0] CsrResetValue = 32'd65536;

   localparam logic CsrBoltzmann = 1'b0;
   localparam logic CsrNorm = 1'b1;

   typedef struct packed {
      logic [31:0] temperature;
      logic [31:0] upper_bound;
      logic        last_group;
      logic [63:0] kt;
   } queue_entry_type;

   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] y;
   } mul_rsp_type;

   typedef struct packed {
      logic        start;
      logic        wide;
      logic [63:0] n;
      logic [63:0] d;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] y;
   } div_rsp_type;

   function automatic logic [63:0] coef_poly(input logic [2:0] idx);
      logic [63:0] c;
      case (idx)
         3'd5: c = CoefP4;
         3'd4: c = CoefP3;
         3'd3: c = CoefP2;
         default: c = CoefP1;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== src/pge_if.sv =====
`default_nettype none
interface pge_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] temperature;
   logic [31:0] upper_bound;
   logic        last_group;
   modport source(output valid, temperature, upper_bound, last_group, input ready);
   modport sink(input valid, temperature, upper_bound, last_group, output ready);
endinterface

interface pge_rsp_if;
   logic        valid;
   logic        ready;
   logic [62:0] emission;
   logic [63:0] emission_deriv;
   logic        last_out;
   modport source(output valid, emission, emission_deriv, last_out, input ready);
   modport sink(input valid, emission, emission_deriv, last_out, output ready);
endinterface
`default_nettype wire

// ===== src/pge_front.sv =====
`default_nettype none
module pge_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   pge_req_if.sink                        req,
   input  wire logic [31:0]               boltzmann,
   input  wire logic                      pop,
   output pge_pkg::queue_entry_type       head,
   output logic                           empty
);

   localparam int Depth = 2;

   pge_pkg::queue_entry_type mem_ff [Depth];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   pge_pkg::queue_entry_type entry;

   assign req.ready = (count_ff != 2'(Depth));
   assign push = req.valid && req.ready;
   assign empty = (count_ff == 2'd0);
   assign head = mem_ff[rd_ptr_ff];

   always_comb begin
      entry.temperature = req.temperature;
      entry.upper_bound = req.upper_bound;
      entry.last_group = req.last_group;
      entry.kt = boltzmann * req.temperature;
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/pge_mul.sv =====
`default_nettype none
module pge_mul (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pge_pkg::mul_req_type req,
   output pge_pkg::mul_rsp_type      rsp
);

   logic [63:0]  a_ff, a_in;
   logic [63:0]  b_ff, b_in;
   logic [127:0] acc_ff, acc_in;
   logic [1:0]   step_ff, step_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [31:0]  pa, pb;
   logic [63:0]  prod;
   logic [127:0] addend;

   always_comb begin
      case (step_ff)
         2'd0: begin
            pa = a_ff[31:0];
            pb = b_ff[31:0];
         end
         2'd1: begin
            pa = a_ff[31:0];
            pb = b_ff[63:32];
         end
         2'd2: begin
            pa = a_ff[63:32];
            pb = b_ff[31:0];
         end
         default: begin
            pa = a_ff[63:32];
            pb = b_ff[63:32];
         end
      endcase
      prod = pa * pb;
      case (step_ff)
         2'd0: addend = {64'd0, prod};
         2'd3: addend = {prod, 64'd0};
         default: addend = {32'd0, prod, 32'd0};
      endcase
      a_in = a_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         a_in = req.a;
         b_in = req.b;
         acc_in = '0;
         step_in = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + addend;
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      rsp.done = done_ff;
      rsp.y = (acc_ff[127:120] != 8'd0) ? '1 : acc_ff[119:56];
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      acc_ff <= acc_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/pge_div.sv =====
`default_nettype none
module pge_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pge_pkg::div_req_type req,
   output pge_pkg::div_rsp_type      rsp
);

   logic [63:0] num_ff, num_in;
   logic [63:0] den_ff, den_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic        ovf_ff, ovf_in;
   logic        dz_ff, dz_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;
   logic        qbit;

   always_comb begin
      trial = {rem_ff, num_ff[63]};
      qbit = (trial >= {1'b0, den_ff});
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      ovf_in = ovf_ff;
      dz_in = dz_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         num_in = req.n;
         den_in = req.d;
         rem_in = '0;
         quo_in = '0;
         ovf_in = 1'b0;
         dz_in = (req.d == 64'd0);
         cnt_in = req.wide ? 7'd119 : 7'd63;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[62:0], 1'b0};
         rem_in = qbit ? 64'(trial - {1'b0, den_ff}) : trial[63:0];
         ovf_in = ovf_ff | quo_ff[63];
         quo_in = {quo_ff[62:0], qbit};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      rsp.done = done_ff;
      rsp.y = (dz_ff || ovf_ff) ? '1 : quo_ff;
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
      dz_ff <= dz_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/pge_back.sv =====
`default_nettype none
module pge_back #(
   parameter int CUM_FRAC_BITS = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire pge_pkg::queue_entry_type  head,
   input  wire logic                      empty,
   output logic                           pop,
   input  wire logic [31:0]               norm,
   output pge_pkg::mul_req_type           mreq,
   input  wire pge_pkg::mul_rsp_type      mrsp,
   output pge_pkg::div_req_type           dreq,
   input  wire pge_pkg::div_rsp_type      drsp,
   pge_rsp_if.source                      rsp
);

   localparam int F = CUM_FRAC_BITS;
   localparam int Lo = pge_pkg::QfBits - F;
   localparam int ShA = F + 48;
   localparam int ShB = F + 62;

   localparam logic [5:0] StIdle = 6'd0;
   localparam logic [5:0] StEps = 6'd1;
   localparam logic [5:0] StE2 = 6'd2;
   localparam logic [5:0] StE3 = 6'd3;
   localparam logic [5:0] StCs1 = 6'd4;
   localparam logic [5:0] StCs2 = 6'd5;
   localparam logic [5:0] StE4 = 6'd6;
   localparam logic [5:0] StE5 = 6'd7;
   localparam logic [5:0] StE7 = 6'd8;
   localparam logic [5:0] StP9 = 6'd9;
   localparam logic [5:0] StP10 = 6'd10;
   localparam logic [5:0] StP11 = 6'd11;
   localparam logic [5:0] StP12 = 6'd12;
   localparam logic [5:0] StXInit = 6'd13;
   localparam logic [5:0] StXm = 6'd14;
   localparam logic [5:0] StXd = 6'd15;
   localparam logic [5:0] StXp = 6'd16;
   localparam logic [5:0] StW0 = 6'd17;
   localparam logic [5:0] StW1 = 6'd18;
   localparam logic [5:0] StW2 = 6'd19;
   localparam logic [5:0] StW3 = 6'd20;
   localparam logic [5:0] StW4 = 6'd21;
   localparam logic [5:0] StWd = 6'd22;
   localparam logic [5:0] StWm = 6'd23;
   localparam logic [5:0] StH6 = 6'd24;
   localparam logic [5:0] StHa = 6'd25;
   localparam logic [5:0] StHb = 6'd26;
   localparam logic [5:0] StHz = 6'd27;
   localparam logic [5:0] StD1 = 6'd28;
   localparam logic [5:0] StD2 = 6'd29;
   localparam logic [5:0] StDv = 6'd30;
   localparam logic [5:0] StDelta = 6'd31;
   localparam logic [5:0] StWs = 6'd32;
   localparam logic [5:0] StWsf = 6'd33;
   localparam logic [5:0] StOut = 6'd34;

   localparam logic [1:0] OpNone = 2'd0;
   localparam logic [1:0] OpMul = 2'd1;
   localparam logic [1:0] OpDiv = 2'd2;

   typedef struct packed {
      logic [31:0]  t;
      logic         last;
      logic [63:0]  kt;
      logic [31:0]  b;
      logic [63:0]  eps;
      logic [63:0]  e2;
      logic [63:0]  e3;
      logic [63:0]  e4;
      logic [63:0]  e5;
      logic [63:0]  e7;
      logic [63:0]  tmp;
      logic [63:0]  h;
      logic [63:0]  r;
      logic [63:0]  e1;
      logic [63:0]  xf;
      logic [63:0]  cum;
      logic [63:0]  der;
      logic [63:0]  sacc;
      logic [4:0]   k;
      logic [5:0]   ip;
      logic [2:0]   hc;
      logic         phase;
      logic [63:0]  mag;
      logic         neg;
      logic [255:0] wacc;
      logic [31:0]  carry;
      logic [2:0]   li;
      logic [2:0]   fi;
      logic         run;
      logic [62:0]  emis;
      logic [63:0]  dout;
   } dp_type;

   dp_type      dp_ff, dp_in;
   logic [5:0]  state_ff, state_in;
   logic        pend_ff, pend_in;
   logic [F:0]  prev_c_ff, prev_c_in;
   logic [F-1:0] prev_d_ff, prev_d_in;
   logic        valid_ff, valid_in;
   logic [62:0] out_emis_ff, out_emis_in;
   logic [63:0] out_dout_ff, out_dout_in;
   logic        out_last_ff, out_last_in;

   logic [1:0]  op;
   logic [63:0] opa, opb;
   logic        wide;
   logic        done;
   logic [63:0] y;
   logic        fire;
   logic [5:0]  after_small;
   logic [5:0]  after_deriv;
   logic [F:0]  cur_c;
   logic [F-1:0] cur_d;
   logic [F+1:0] dc, dd;
   logic [F+2:0] diff, magv;
   logic        dc_pos;
   logic [31:0] factor;
   logic [63:0] prod;
   logic [255:0] shifted;
   logic [62:0] sval;
   logic [63:0] s_sum;

   assign rsp.valid = valid_ff;
   assign rsp.emission = out_emis_ff;
   assign rsp.emission_deriv = out_dout_ff;
   assign rsp.last_out = out_last_ff;

   always_comb begin
      op = OpNone;
      opa = '0;
      opb = '0;
      wide = 1'b0;
      case (state_ff)
         StEps: begin
            op = OpDiv;
            opa = {16'd0, dp_ff.b, 16'd0};
            opb = dp_ff.kt;
            wide = 1'b1;
         end
         StE2: begin
            op = OpMul; opa = dp_ff.eps; opb = dp_ff.eps;
         end
         StE3: begin
            op = OpMul; opa = dp_ff.e2; opb = dp_ff.eps;
         end
         StCs1: begin
            op = OpMul; opa = pge_pkg::CoefA2; opb = dp_ff.eps;
         end
         StCs2: begin
            op = OpMul; opa = dp_ff.e3; opb = pge_pkg::CoefA1 - dp_ff.tmp;
         end
         StE4: begin
            op = OpMul; opa = dp_ff.e2; opb = dp_ff.e2;
         end
         StE5: begin
            op = OpMul; opa = dp_ff.e4; opb = dp_ff.eps;
         end
         StE7: begin
            op = OpMul; opa = dp_ff.e5; opb = dp_ff.e2;
         end
         StP9: begin
            op = OpMul; opa = pge_pkg::CoefS3; opb = dp_ff.e3;
         end
         StP10: begin
            op = OpMul; opa = pge_pkg::CoefS4; opb = dp_ff.e4;
         end
         StP11: begin
            op = OpMul; opa = pge_pkg::CoefS5; opb = dp_ff.e5;
         end
         StP12: begin
            op = OpMul; opa = pge_pkg::CoefS7; opb = dp_ff.e7;
         end
         StXm: begin
            op = OpMul; opa = dp_ff.xf; opb = dp_ff.r;
         end
         StXd: begin
            op = OpDiv; opa = dp_ff.tmp; opb = {59'd0, dp_ff.k};
         end
         StXp: begin
            op = OpMul; opa = dp_ff.r; opb = dp_ff.e1;
         end
         StW1: begin
            op = OpMul; opa = dp_ff.r; opb = dp_ff.eps;
         end
         StW2, StW3, StW4: begin
            op = OpMul; opa = dp_ff.tmp; opb = dp_ff.eps;
         end
         StWd: begin
            op = OpDiv; opa = dp_ff.tmp; opb = pge_pkg::One - dp_ff.r; wide = 1'b1;
         end
         StWm: begin
            op = OpMul; opa = pge_pkg::CoefNorm; opb = dp_ff.tmp;
         end
         StH6: begin
            op = OpMul; opa = dp_ff.r; opb = pge_pkg::CoefP5;
         end
         StHa: begin
            op = OpMul; opa = dp_ff.r; opb = pge_pkg::coef_poly(dp_ff.hc);
         end
         StHb, StHz: begin
            op = OpMul; opa = dp_ff.eps; opb = dp_ff.h;
         end
         StD1: begin
            op = OpMul; opa = dp_ff.eps; opb = pge_pkg::CoefQ2;
         end
         StD2: begin
            op = OpMul; opa = dp_ff.eps; opb = pge_pkg::CoefQ1 + dp_ff.tmp;
         end
         StDv: begin
            op = OpDiv; opa = dp_ff.h; opb = dp_ff.tmp; wide = 1'b1;
         end
         default: begin
            op = OpNone;
         end
      endcase
   end

   always_comb begin
      done = (op == OpMul) ? mrsp.done : drsp.done;
      y = (op == OpMul) ? mrsp.y : drsp.y;
      fire = (op != OpNone) && pend_ff && done;
      mreq.start = (op == OpMul) && !pend_ff;
      mreq.a = opa;
      mreq.b = opb;
      dreq.start = (op == OpDiv) && !pend_ff;
      dreq.wide = wide;
      dreq.n = opa;
      dreq.d = opb;

      after_small = (dp_ff.eps < pge_pkg::Thr1000) ? StE4 : StXInit;
      after_deriv = (dp_ff.eps >= pge_pkg::Thr100) ? StH6 : StDelta;

      cur_c = dp_ff.cum[pge_pkg::QfBits:Lo];
      cur_d = dp_ff.der[pge_pkg::QfBits-1:Lo];
      dc = {1'b0, cur_c} - {1'b0, prev_c_ff};
      dd = {2'b0, cur_d} - {2'b0, prev_d_ff};
      diff = {dc[F+1], dc} - {dd[F+1], dd};
      magv = diff[F+2] ? (F+3)'(0) - diff : diff;
      dc_pos = !dc[F+1] && (dc != '0);

      factor = (dp_ff.fi == 3'd0) ? norm : dp_ff.t;
      prod = dp_ff.wacc[31:0] * factor;
      prod = prod + {32'd0, dp_ff.carry};
      shifted = dp_ff.run ? (dp_ff.wacc >> ShB) : (dp_ff.wacc >> ShA);
      sval = (shifted[255:63] != '0) ? pge_pkg::Sat63 : shifted[62:0];
      s_sum = dp_ff.sacc - y;
   end

   always_comb begin
      dp_in = dp_ff;
      state_in = state_ff;
      pend_in = pend_ff;
      prev_c_in = prev_c_ff;
      prev_d_in = prev_d_ff;
      valid_in = valid_ff && !rsp.ready;
      out_emis_in = out_emis_ff;
      out_dout_in = out_dout_ff;
      out_last_in = out_last_ff;
      pop = 1'b0;
      if (op != OpNone && !pend_ff) begin
         pend_in = 1'b1;
      end
      if (fire) begin
         pend_in = 1'b0;
      end
      case (state_ff)
         StIdle: begin
            if (!empty) begin
               pop = 1'b1;
               dp_in.t = head.temperature;
               dp_in.b = head.upper_bound;
               dp_in.last = head.last_group;
               dp_in.kt = head.kt;
               dp_in.cum = pge_pkg::One;
               dp_in.der = '0;
               if (head.kt == 64'd0) begin
                  dp_in.emis = '0;
                  dp_in.dout = '0;
                  if (head.last_group) begin
                     prev_c_in = '0;
                     prev_d_in = '0;
                  end
                  state_in = StOut;
               end else if (head.last_group) begin
                  state_in = StDelta;
               end else begin
                  state_in = StEps;
               end
            end
         end
         StEps: if (fire) begin
            dp_in.eps = (y > pge_pkg::EpsCap) ? pge_pkg::EpsCap : y;
            state_in = StE2;
         end
         StE2: if (fire) begin
            dp_in.e2 = y;
            state_in = StE3;
         end
         StE3: if (fire) begin
            dp_in.e3 = y;
            state_in = (dp_ff.eps < pge_pkg::Thr100) ? StCs1 : StXInit;
         end
         StCs1: if (fire) begin
            dp_in.tmp = y;
            state_in = StCs2;
         end
         StCs2: if (fire) begin
            dp_in.cum = y;
            state_in = after_small;
         end
         StE4: if (fire) begin
            dp_in.e4 = y;
            state_in = StE5;
         end
         StE5: if (fire) begin
            dp_in.e5 = y;
            state_in = StE7;
         end
         StE7: if (fire) begin
            dp_in.e7 = y;
            state_in = StP9;
         end
         StP9: if (fire) begin
            dp_in.sacc = y;
            state_in = StP10;
         end
         StP10: if (fire) begin
            dp_in.sacc = dp_ff.sacc - y;
            state_in = StP11;
         end
         StP11: if (fire) begin
            dp_in.sacc = dp_ff.sacc + y;
            state_in = StP12;
         end
         StP12: if (fire) begin
            dp_in.der = s_sum[63] ? 64'd0 : s_sum;
            state_in = StDelta;
         end
         StXInit: begin
            dp_in.xf = pge_pkg::One;
            dp_in.r = pge_pkg::One;
            dp_in.k = 5'd20;
            dp_in.phase = 1'b0;
            state_in = StXm;
         end
         StXm: if (fire) begin
            dp_in.tmp = y;
            state_in = StXd;
         end
         StXd: if (fire) begin
            dp_in.r = pge_pkg::One - y;
            dp_in.k = dp_ff.k - 5'd1;
            state_in = StXm;
            if (dp_ff.k == 5'd1) begin
               if (!dp_ff.phase) begin
                  dp_in.e1 = pge_pkg::One - y;
                  dp_in.xf = {8'd0, dp_ff.eps[55:0]};
                  dp_in.r = pge_pkg::One;
                  dp_in.k = 5'd20;
                  dp_in.phase = 1'b1;
               end else begin
                  dp_in.ip = dp_ff.eps[61:56];
                  state_in = (dp_ff.eps[61:56] == 6'd0) ? StW0 : StXp;
               end
            end
         end
         StXp: if (fire) begin
            dp_in.r = y;
            dp_in.ip = dp_ff.ip - 6'd1;
            if (dp_ff.ip == 6'd1) begin
               state_in = StW0;
            end
         end
         StW0: begin
            if (dp_ff.r >= pge_pkg::One) begin
               dp_in.der = '0;
               state_in = after_deriv;
            end else begin
               state_in = StW1;
            end
         end
         StW1: if (fire) begin
            dp_in.tmp = y;
            state_in = StW2;
         end
         StW2: if (fire) begin
            dp_in.tmp = y;
            state_in = StW3;
         end
         StW3: if (fire) begin
            dp_in.tmp = y;
            state_in = StW4;
         end
         StW4: if (fire) begin
            dp_in.tmp = {2'd0, y[63:2]};
            state_in = StWd;
         end
         StWd: if (fire) begin
            dp_in.tmp = y;
            state_in = StWm;
         end
         StWm: if (fire) begin
            dp_in.der = y;
            state_in = after_deriv;
         end
         StH6: if (fire) begin
            dp_in.h = y;
            dp_in.hc = 3'd5;
            state_in = StHa;
         end
         StHa: if (fire) begin
            dp_in.tmp = y;
            state_in = StHb;
         end
         StHb: if (fire) begin
            dp_in.h = dp_ff.tmp + y;
            dp_in.hc = dp_ff.hc - 3'd1;
            state_in = (dp_ff.hc == 3'd2) ? StHz : StHa;
         end
         StHz: if (fire) begin
            dp_in.h = dp_ff.r + y;
            state_in = StD1;
         end
         StD1: if (fire) begin
            dp_in.tmp = y;
            state_in = StD2;
         end
         StD2: if (fire) begin
            dp_in.tmp = pge_pkg::One + y;
            state_in = StDv;
         end
         StDv: if (fire) begin
            dp_in.cum = (y >= pge_pkg::One) ? 64'd0 : pge_pkg::One - y;
            state_in = StDelta;
         end
         StDelta: begin
            if (dp_ff.last) begin
               prev_c_in = '0;
               prev_d_in = '0;
            end else begin
               prev_c_in = cur_c;
               prev_d_in = cur_d;
            end
            dp_in.neg = diff[F+2];
            dp_in.mag = 64'(magv);
            dp_in.wacc = dc_pos ? 256'(dc[F:0]) : '0;
            dp_in.carry = '0;
            dp_in.li = '0;
            dp_in.fi = '0;
            dp_in.run = 1'b0;
            state_in = StWs;
         end
         StWs: begin
            dp_in.wacc = {prod[31:0], dp_ff.wacc[255:32]};
            dp_in.carry = prod[63:32];
            dp_in.li = dp_ff.li + 3'd1;
            if (dp_ff.li == 3'd7) begin
               dp_in.carry = '0;
               dp_in.fi = dp_ff.fi + 3'd1;
               if (dp_ff.fi == (dp_ff.run ? 3'd3 : 3'd4)) begin
                  state_in = StWsf;
               end
            end
         end
         StWsf: begin
            if (!dp_ff.run) begin
               dp_in.emis = sval;
               dp_in.wacc = 256'(dp_ff.mag);
               dp_in.run = 1'b1;
               dp_in.fi = '0;
               dp_in.li = '0;
               dp_in.carry = '0;
               state_in = StWs;
            end else begin
               dp_in.dout = dp_ff.neg ? 64'd0 - {1'b0, sval} : {1'b0, sval};
               state_in = StOut;
            end
         end
         StOut: begin
            if (!valid_ff || rsp.ready) begin
               valid_in = 1'b1;
               out_emis_in = dp_ff.emis;
               out_dout_in = dp_ff.dout;
               out_last_in = dp_ff.last;
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      dp_ff <= dp_in;
      out_emis_ff <= out_emis_in;
      out_dout_ff <= out_dout_in;
      out_last_ff <= out_last_in;
      if (reset) begin
         state_ff <= StIdle;
         pend_ff <= 1'b0;
         prev_c_ff <= '0;
         prev_d_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff <= pend_in;
         prev_c_ff <= prev_c_in;
         prev_d_ff <= prev_d_in;
         valid_ff <= valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/planck_group_emission.sv =====
// Banded Planck emission and its temperature derivative for one energy group per
// transfer. A two-entry input queue forms k*T and holds items while a sequencer works
// on one item at a time through a shared multiplier (one 32x32 partial product per
// cycle) and a bit-serial divider. For an ordinary group below eps 0.001 a short series
// replaces the exponential; above it the exponential is formed by two 20-step series,
// each step one product and one division, plus up to 48 products for the integer part
// of the exponent. A last group skips these series, and an item with zero k*T gives
// zero results. One result is given per item, in order, and a finished result waits
// in an output register while the next item is worked on.
`default_nettype none
module planck_group_emission #(
   parameter int CUM_FRAC_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   pge_req_if.sink          req_ch,
   pge_rsp_if.source        rsp_ch,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata
);

   logic [31:0] boltzmann_ff, boltzmann_in;
   logic [31:0] norm_ff, norm_in;
   pge_pkg::queue_entry_type head;
   logic q_empty;
   logic q_pop;
   pge_pkg::mul_req_type mreq;
   pge_pkg::mul_rsp_type mrsp;
   pge_pkg::div_req_type dreq;
   pge_pkg::div_rsp_type drsp;

   always_comb begin
      boltzmann_in = boltzmann_ff;
      norm_in = norm_ff;
      if (csr_wr_en) begin
         case (csr_index)
            pge_pkg::CsrBoltzmann: boltzmann_in = csr_wdata;
            pge_pkg::CsrNorm: norm_in = csr_wdata;
            default: boltzmann_in = boltzmann_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         boltzmann_ff <= pge_pkg::CsrResetValue;
         norm_ff <= pge_pkg::CsrResetValue;
      end else begin
         boltzmann_ff <= boltzmann_in;
         norm_ff <= norm_in;
      end
   end

   pge_front u_front (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .boltzmann(boltzmann_ff),
      .pop(q_pop),
      .head(head),
      .empty(q_empty)
   );

   pge_mul u_mul (
      .clock(clock),
      .reset(reset),
      .req(mreq),
      .rsp(mrsp)
   );

   pge_div u_div (
      .clock(clock),
      .reset(reset),
      .req(dreq),
      .rsp(drsp)
   );

   pge_back #(
      .CUM_FRAC_BITS(CUM_FRAC_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .empty(q_empty),
      .pop(q_pop),
      .norm(norm_ff),
      .mreq(mreq),
      .mrsp(mrsp),
      .dreq(dreq),
      .drsp(drsp),
      .rsp(rsp_ch)
   );

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("Queue popped while empty.");

   a_single_unit: assert property (@(posedge clock) disable iff (reset)
      mreq.start |-> !dreq.start)
      else $error("Multiplier and divider started together.");

   a_mul_done_pulse: assert property (@(posedge clock) disable iff (reset)
      mrsp.done |=> !mrsp.done)
      else $error("Multiplier done held for more than one cycle.");

endmodule
`default_nettype wire
